// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/q2e_pkg.sv -----
// Package for the quaternion to Euler angle converter: widths, stage
// indexes, the CORDIC arctangent table and the term bundle. No dependencies.
package q2e_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQ_STEPS     = 29;
  localparam int TERM_W       = 38;
  localparam int S_W          = 30;
  localparam int RAD_W        = 57;
  localparam int RAD_PAD      = 2 * SQ_STEPS;
  localparam int ROOT_W       = SQ_STEPS;
  localparam int ACC_W        = 25;
  localparam int ANG_W        = 17;
  localparam int WRAP_W       = 18;

  // Stage indexes of the valid chain.
  localparam int ST_SQ0  = 4;
  localparam int ST_CPRE = ST_SQ0 + SQ_STEPS;
  localparam int ST_OUT  = ST_CPRE + CORDIC_STEPS + 1;
  localparam int NST     = ST_OUT + 1;

  localparam logic signed [TERM_W-1:0] ONE_Q28  = 38'sd268435456;
  localparam logic signed [TERM_W-1:0] S_LIMIT  = 38'sd268435456;
  localparam logic signed [59:0]       RAD_FULL = 60'sd72057594037927936;
  localparam logic signed [ACC_W-1:0]  DEG90    = 25'sd2949120;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = 25'sd128;
  localparam logic signed [WRAP_W-1:0] HALF_TURN = 18'sd23040;
  localparam logic signed [WRAP_W-1:0] FULL_TURN = 18'sd46080;
  localparam logic signed [WRAP_W-1:0] PITCH_LIMIT = 18'sd11520;

  // atan(2^-i) in 1/32768 degree, rounded to nearest.
  localparam logic signed [ACC_W-1:0] ATAN_TAB [24] = '{
    25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
    25'sd117189, 25'sd58652, 25'sd29333, 25'sd14667,
    25'sd7334, 25'sd3667, 25'sd1833, 25'sd917,
    25'sd458, 25'sd229, 25'sd115, 25'sd57,
    25'sd29, 25'sd14, 25'sd7, 25'sd4,
    25'sd2, 25'sd1, 25'sd0, 25'sd0
  };

  // Vector terms for roll and yaw plus the clamped pitch sine.
  typedef struct packed {
    logic signed [TERM_W-1:0] roll_y;
    logic signed [TERM_W-1:0] roll_x;
    logic signed [TERM_W-1:0] yaw_y;
    logic signed [TERM_W-1:0] yaw_x;
    logic signed [S_W-1:0]    sine;
  } term_t;

endpackage

// ----- sv/q2e_isqrt.sv -----
// Pipelined floor square root, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt (
  input  logic                           clk,
  input  logic [q2e_pkg::SQ_STEPS-1:0]   en,
  input  logic [q2e_pkg::RAD_W-1:0]      rad,
  output logic [q2e_pkg::ROOT_W-1:0]     root
);
  import q2e_pkg::*;

  logic [RAD_PAD-1:0] nq [SQ_STEPS];
  logic [ROOT_W-1:0]  rq [SQ_STEPS];
  logic [ROOT_W+1:0]  mq [SQ_STEPS];

  genvar k;
  for (k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [RAD_PAD-1:0] n_in;
    logic [ROOT_W-1:0]  r_in;
    logic [ROOT_W+1:0]  m_in;
    logic [ROOT_W+1:0]  m_t;
    logic [ROOT_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign n_in = RAD_PAD'(rad);
      assign r_in = '0;
      assign m_in = '0;
    end else begin : g_next
      assign n_in = nq[k-1];
      assign r_in = rq[k-1];
      assign m_in = mq[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign m_t   = {m_in[ROOT_W-1:0], n_in[RAD_PAD-1 -: 2]};
    assign trial = {r_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        nq[k] <= n_in << 2;
        if (m_t >= trial) begin
          mq[k] <= m_t - trial;
          rq[k] <= {r_in[ROOT_W-2:0], 1'b1};
        end else begin
          mq[k] <= m_t;
          rq[k] <= {r_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rq[SQ_STEPS-1];

endmodule

// ----- sv/q2e_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2(y, x) in 1/128 degree, rounded.
// Depends on q2e_pkg.
module q2e_cordic (
  input  logic                                 clk,
  input  logic [q2e_pkg::CORDIC_STEPS:0]       en,
  input  logic signed [q2e_pkg::TERM_W-1:0]    vec_y,
  input  logic signed [q2e_pkg::TERM_W-1:0]    vec_x,
  output logic signed [q2e_pkg::ANG_W-1:0]     angle
);
  import q2e_pkg::*;

  logic signed [TERM_W-1:0] xq [CORDIC_STEPS+1];
  logic signed [TERM_W-1:0] yq [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0]  aq [CORDIC_STEPS+1];
  logic                     zq [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0]  rounded;

  // Zero check and quarter turn into the right half plane.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zq[0] <= (vec_x == '0) && (vec_y == '0);
      if (vec_x < 0) begin
        if (vec_y >= 0) begin
          xq[0] <= vec_y;
          yq[0] <= -vec_x;
          aq[0] <= DEG90;
        end else begin
          xq[0] <= -vec_y;
          yq[0] <= vec_x;
          aq[0] <= -DEG90;
        end
      end else begin
        xq[0] <= vec_x;
        yq[0] <= vec_y;
        aq[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage.
  genvar i;
  for (i = 1; i <= CORDIC_STEPS; i++) begin : g_iter
    logic signed [TERM_W-1:0] dx;
    logic signed [TERM_W-1:0] dy;
    assign dx = yq[i-1] >>> (i - 1);
    assign dy = xq[i-1] >>> (i - 1);

    always_ff @(posedge clk) begin
      if (en[i]) begin
        zq[i] <= zq[i-1];
        if (yq[i-1] >= 0) begin
          xq[i] <= xq[i-1] + dx;
          yq[i] <= yq[i-1] - dy;
          aq[i] <= aq[i-1] + ATAN_TAB[i-1];
        end else begin
          xq[i] <= xq[i-1] - dx;
          yq[i] <= yq[i-1] + dy;
          aq[i] <= aq[i-1] - ATAN_TAB[i-1];
        end
      end
    end
  end

  // Round from 1/32768 to 1/128 degree, halves up.
  assign rounded = (aq[CORDIC_STEPS] + ROUND_HALF) >>> 8;
  assign angle   = zq[CORDIC_STEPS] ? '0 : rounded[ANG_W-1:0];

endmodule

// ----- sv/quaternion_to_euler_angles.sv -----
// Top level of the quaternion to Euler angle converter (ZYX convention).
// Depends on q2e_pkg, q2e_isqrt and q2e_cordic.
//
//   channel  direction  fields (lowest bit up)
//   s_axis   in         quat_w, quat_x, quat_y, quat_z (16 bits each)
//   m_axis   out        roll_angle 16, pitch_angle 15, yaw_angle 16, pad 1
//   cfg      in         yaw_zero_offset 16
//
// One beat is accepted per cycle unless the output stalls. NST stages: four input,
// product and sum stages, 29 square root stages (one root bit each), 17 CORDIC
// stages and one output stage. Each stage holds a valid bit and moves on when the
// stage after it is empty or moving, so a stall loses or repeats nothing.
// Synchronous reset clears the valid bits and the yaw offset.
module quaternion_to_euler_angles (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // yaw_zero_offset
);
  import q2e_pkg::*;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  term_t              t2, t3;
  logic [RAD_W-1:0]   rad3;
  term_t              td [SQ_STEPS];
  logic [ROOT_W-1:0]  cos_root;
  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;
  logic signed [15:0] yaw_offset;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;

  logic signed [TERM_W-1:0] s_raw;
  logic signed [59:0]       s_sq;
  logic signed [WRAP_W-1:0] roll_w, yaw_d, pitch_w;
  logic signed [WRAP_W-1:0] roll_next, yaw_next, pitch_next;

  // Ready chain: a stage moves when it is empty or its successor moves.
  assign en[NST-1] = !v[NST-1] || m_axis_tready;
  genvar g;
  for (g = 0; g < NST-1; g++) begin : g_ready
    assign en[g] = !v[g] || en[g+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[NST-1];

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset <= '0;
    end else if (cfg_valid) begin
      yaw_offset <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      qw <= s_axis_tdata[15:0];
      qx <= s_axis_tdata[31:16];
      qy <= s_axis_tdata[47:32];
      qz <= s_axis_tdata[63:48];
    end
  end

  // Component products, exact in Q4.28.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
  end

  // Vector terms and the clamped pitch sine.
  assign s_raw = (TERM_W'(p_wy) - TERM_W'(p_zx)) <<< 1;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t2.roll_y <= (TERM_W'(p_wx) + TERM_W'(p_yz)) <<< 1;
      t2.roll_x <= ONE_Q28 - ((TERM_W'(p_yy) + TERM_W'(p_xx)) <<< 1);
      t2.yaw_y  <= (TERM_W'(p_wz) + TERM_W'(p_xy)) <<< 1;
      t2.yaw_x  <= ONE_Q28 - ((TERM_W'(p_yy) + TERM_W'(p_zz)) <<< 1);
      if (s_raw > S_LIMIT) begin
        t2.sine <= S_LIMIT[S_W-1:0];
      end else if (s_raw < -S_LIMIT) begin
        t2.sine <= S_W'(-S_LIMIT);
      end else begin
        t2.sine <= s_raw[S_W-1:0];
      end
    end
  end

  // Radicand 1 - s^2 for the cosine.
  assign s_sq = t2.sine * t2.sine;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3   <= t2;
      rad3 <= RAD_W'(RAD_FULL - s_sq);
    end
  end

  q2e_isqrt u_isqrt (
    .clk  (clk),
    .en   (en[ST_SQ0 +: SQ_STEPS]),
    .rad  (rad3),
    .root (cos_root)
  );

  // Terms ride alongside the square root stages.
  for (g = 0; g < SQ_STEPS; g++) begin : g_delay
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[ST_SQ0]) begin
          td[0] <= t3;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[ST_SQ0+g]) begin
          td[g] <= td[g-1];
        end
      end
    end
  end

  q2e_cordic u_roll (
    .clk   (clk),
    .en    (en[ST_CPRE +: CORDIC_STEPS+1]),
    .vec_y (td[SQ_STEPS-1].roll_y),
    .vec_x (td[SQ_STEPS-1].roll_x),
    .angle (roll_a)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .en    (en[ST_CPRE +: CORDIC_STEPS+1]),
    .vec_y (TERM_W'(td[SQ_STEPS-1].sine)),
    .vec_x ($signed({{(TERM_W-ROOT_W){1'b0}}, cos_root})),
    .angle (pitch_a)
  );

  q2e_cordic u_yaw (
    .clk   (clk),
    .en    (en[ST_CPRE +: CORDIC_STEPS+1]),
    .vec_y (td[SQ_STEPS-1].yaw_y),
    .vec_x (td[SQ_STEPS-1].yaw_x),
    .angle (yaw_a)
  );

  // Subtract the yaw offset, wrap roll and yaw into one half turn, saturate pitch.
  always_comb begin
    roll_w  = WRAP_W'(roll_a);
    yaw_d   = WRAP_W'(yaw_a) - WRAP_W'(yaw_offset);
    pitch_w = WRAP_W'(pitch_a);
    if (roll_w > HALF_TURN) begin
      roll_next = roll_w - FULL_TURN;
    end else if (roll_w < -HALF_TURN) begin
      roll_next = roll_w + FULL_TURN;
    end else begin
      roll_next = roll_w;
    end
    if (yaw_d > HALF_TURN) begin
      yaw_next = yaw_d - FULL_TURN;
    end else if (yaw_d < -HALF_TURN) begin
      yaw_next = yaw_d + FULL_TURN;
    end else begin
      yaw_next = yaw_d;
    end
    if (pitch_w > PITCH_LIMIT) begin
      pitch_next = PITCH_LIMIT;
    end else if (pitch_w < -PITCH_LIMIT) begin
      pitch_next = -PITCH_LIMIT;
    end else begin
      pitch_next = pitch_w;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      roll_q  <= roll_next[15:0];
      pitch_q <= pitch_next[14:0];
      yaw_q   <= yaw_next[15:0];
    end
  end

  assign m_axis_tdata = {1'b0, yaw_q, pitch_q, roll_q};

endmodule

// ----- sv/q2e_checker.sv -----
// Port-level checker for the quaternion to Euler angle converter, with bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module q2e_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  // A stalled result beat stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // Reset empties the pipeline.
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "result offered after reset")

  // Roll stays within one half turn.
  `ASSERT_CLK(a_roll_rng, clk, rst, m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040 && $signed(m_axis_tdata[15:0]) >= -16'sd23040), "roll out of range")

  // Pitch stays within a quarter turn and the pad bit is zero.
  `ASSERT_CLK(a_pitch_rng, clk, rst, m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd11520 && $signed(m_axis_tdata[30:16]) >= -15'sd11520 && !m_axis_tdata[47]), "pitch out of range")

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
